/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL modules of the collision checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define POC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication.
`define POC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/poc_pkg.sv */
// Package of the point obstacle collision checker: sizes, codes and types.
// Used by every module of the block and by poc_cmd_if; depends on nothing.
package poc_pkg;

  localparam int MAX_OBSTACLES = 64;
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int CNT_W = $clog2(MAX_OBSTACLES + 1);

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 16;
  localparam int DIFF_W  = COORD_W + 2;
  localparam int RAD_W   = SIZE_W + 2;
  localparam int SQ_W    = 2 * DIFF_W - 1;
  localparam int RR_W    = 2 * RAD_W;
  localparam int CMP_W   = SQ_W + 2;

  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;
  localparam int FILL_W      = QUEUE_AW + 1;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD   = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] KIND_SPHERE = 2'd0;
  localparam logic [1:0] KIND_CYL    = 2'd1;

  localparam logic [REG_IDX_W-1:0] REG_CLEARANCE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_MIN_X = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_MAX_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_MIN_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_MAX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_MIN_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_MAX_Z = 3'd6;

  typedef enum logic [2:0] {
    ST_QUERY   = 3'd0,
    ST_STORED  = 3'd1,
    ST_IGNORED = 3'd2,
    ST_FULL    = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_STORE,
    OP_IGNORE,
    OP_FULL,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_REPLY
  } bk_state_t;

  typedef struct packed {
    logic        [SIZE_W-1:0]  clearance;
    logic signed [COORD_W-1:0] bound_min_x;
    logic signed [COORD_W-1:0] bound_max_x;
    logic signed [COORD_W-1:0] bound_min_y;
    logic signed [COORD_W-1:0] bound_max_y;
    logic signed [COORD_W-1:0] bound_min_z;
    logic signed [COORD_W-1:0] bound_max_z;
  } poc_cfg_t;

  localparam poc_cfg_t CFG_RESET = '{
    clearance:     16'd128,
    bound_min_x:   -16'sd5120,
    bound_max_x:   16'sd5120,
    bound_min_y:   -16'sd5120,
    bound_max_y:   16'sd5120,
    bound_min_z:   16'sd0,
    bound_max_z:   16'sd2560
  };

  // Classified command; idx is the table slot for a store and the entry count for a query.
  typedef struct packed {
    op_t                       op;
    logic        [CNT_W-1:0]   idx;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      is_cyl;
    logic        [SIZE_W-1:0]  diam;
    logic        [SIZE_W-1:0]  hgt;
  } cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic                      is_cyl;
    logic        [SIZE_W-1:0]  diam;
    logic        [SIZE_W-1:0]  hgt;
  } entry_t;

endpackage

/* hw/rtl/poc_if.sv */
// Valid/ready channel interfaces for the command and result streams.
// Depends on poc_pkg for the field widths.
interface poc_cmd_if import poc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic        [1:0]         mode;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic        [1:0]         shape_kind;
  logic        [SIZE_W-1:0]  diameter;
  logic        [SIZE_W-1:0]  height;

  modport source (output valid, mode, pos_x, pos_y, pos_z, shape_kind, diameter, height,
                  input ready);
  modport sink (input valid, mode, pos_x, pos_y, pos_z, shape_kind, diameter, height,
                output ready);
endinterface

interface poc_res_if ();
  logic       valid;
  logic       ready;
  logic       point_free;
  logic [2:0] status;

  modport source (output valid, point_free, status, input ready);
  modport sink (input valid, point_free, status, output ready);
endinterface

/* hw/rtl/poc_fifo.sv */
// Short command queue between the front classifier and the back executor.
// Depends on poc_pkg for the command type and queue depth.
module poc_fifo import poc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic push_ready,
  input  logic pop,
  output cmd_t pop_data,
  output logic pop_valid
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [FILL_W-1:0]   fill;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + FILL_W'(do_push) - FILL_W'(do_pop);
    end
  end

endmodule

/* hw/rtl/poc_front.sv */
// Front end: accepts command transfers, keeps the obstacle count and classifies each item.
// Depends on poc_pkg and poc_cmd_if; feeds poc_fifo.
module poc_front import poc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  poc_cmd_if.sink    cmd,
  output logic       push,
  output cmd_t       push_data,
  input  logic       queue_ready
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  assign cmd.ready = queue_ready;
  assign push      = cmd.valid && queue_ready;

  always_comb begin
    push_data.op     = OP_IGNORE;
    push_data.idx    = count;
    push_data.pos_x  = cmd.pos_x;
    push_data.pos_y  = cmd.pos_y;
    push_data.pos_z  = cmd.pos_z;
    push_data.is_cyl = (cmd.shape_kind == KIND_CYL);
    push_data.diam   = cmd.diameter;
    push_data.hgt    = cmd.height;
    count_next       = count;
    unique case (cmd.mode)
      MODE_CLEAR: begin
        push_data.op = OP_CLEAR;
        count_next   = '0;
      end
      MODE_ADD: begin
        if (cmd.shape_kind != KIND_SPHERE && cmd.shape_kind != KIND_CYL) begin
          push_data.op = OP_IGNORE;
        end else if (count >= CNT_W'(MAX_OBSTACLES)) begin
          push_data.op = OP_FULL;
        end else begin
          push_data.op = OP_STORE;
          count_next   = count + 1'b1;
        end
      end
      MODE_QUERY: begin
        push_data.op = OP_QUERY;
      end
      default: begin
        push_data.op = OP_IGNORE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

/* hw/rtl/poc_back.sv */
// Back end: obstacle memory, pipelined distance test over stored entries and result register.
// Depends on poc_pkg, poc_res_if and assert_macros.svh; fed by poc_fifo.
`include "assert_macros.svh"

module poc_back import poc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  poc_cfg_t cfg,
  input  cmd_t     cmd,
  input  logic     cmd_valid,
  output logic     cmd_pop,
  poc_res_if.source res
);

  bk_state_t state;
  bk_state_t state_next;

  entry_t obst_mem [MAX_OBSTACLES];
  entry_t rd_q;

  logic [CNT_W-1:0]          scan_idx;
  logic [CNT_W-1:0]          scan_n;
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic signed [COORD_W-1:0] qz;
  logic                      in_box;
  logic                      hit;

  logic v1;
  logic v2;
  logic v3;

  logic signed [DIFF_W-1:0] s2_dx;
  logic signed [DIFF_W-1:0] s2_dy;
  logic signed [DIFF_W-1:0] s2_dz;
  logic [RAD_W-1:0]         s2_r;
  logic                     s2_cyl;
  logic [SIZE_W-1:0]        s2_hgt;

  logic [SQ_W-1:0] s3_sqx;
  logic [SQ_W-1:0] s3_sqy;
  logic [SQ_W-1:0] s3_sqz;
  logic [RR_W-1:0] s3_rr;
  logic            s3_cyl;
  logic            s3_zin;

  logic                res_valid;
  logic                res_free;
  status_t             res_status;

  logic                out_free;
  logic                scan_more;
  logic                drained;
  logic                box_ok;
  logic                issue;
  logic                load;
  logic                load_free;
  status_t             load_status;
  logic                mem_we;
  logic                start_query;

  logic signed [COORD_W:0]     ex;
  logic signed [COORD_W:0]     ey;
  logic signed [COORD_W:0]     ez;
  logic [DIFF_W-1:0]           adz;
  logic signed [2*DIFF_W-1:0]  px2;
  logic signed [2*DIFF_W-1:0]  py2;
  logic signed [2*DIFF_W-1:0]  pz2;
  logic [RR_W-1:0]             rr;
  logic [CMP_W-1:0]            sxy;
  logic [CMP_W-1:0]            sxyz;
  logic                        hit_now;

  assign res.valid      = res_valid;
  assign res.point_free = res_free;
  assign res.status     = res_status;

  assign out_free    = !res_valid || res.ready;
  assign scan_more   = (scan_idx < scan_n);
  assign drained     = !(v1 || v2 || v3);
  assign start_query = cmd_pop && (cmd.op == OP_QUERY);

  assign box_ok = (cmd.pos_x >= cfg.bound_min_x) && (cmd.pos_x <= cfg.bound_max_x) &&
                  (cmd.pos_y >= cfg.bound_min_y) && (cmd.pos_y <= cfg.bound_max_y) &&
                  (cmd.pos_z >= cfg.bound_min_z) && (cmd.pos_z <= cfg.bound_max_z);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && cmd.op == OP_QUERY) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (!scan_more) begin
          state_next = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (drained) begin
          state_next = BK_REPLY;
        end
      end
      BK_REPLY: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop     = 1'b0;
    load        = 1'b0;
    load_free   = 1'b0;
    load_status = ST_QUERY;
    issue       = 1'b0;
    mem_we      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          if (cmd.op == OP_QUERY) begin
            cmd_pop = 1'b1;
          end else if (out_free) begin
            cmd_pop = 1'b1;
            load    = 1'b1;
            mem_we  = (cmd.op == OP_STORE);
            unique case (cmd.op)
              OP_CLEAR: load_status = ST_CLEARED;
              OP_STORE: load_status = ST_STORED;
              OP_FULL:  load_status = ST_FULL;
              default:  load_status = ST_IGNORED;
            endcase
          end
        end
      end
      BK_SCAN: begin
        issue = scan_more;
      end
      BK_DRAIN: begin
        issue = 1'b0;
      end
      BK_REPLY: begin
        load      = out_free;
        load_free = in_box && !hit;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      obst_mem[cmd.idx[IDX_W-1:0]] <= '{
        cx: cmd.pos_x, cy: cmd.pos_y, cz: cmd.pos_z,
        is_cyl: cmd.is_cyl, diam: cmd.diam, hgt: cmd.hgt
      };
    end
    if (issue) begin
      rd_q <= obst_mem[scan_idx[IDX_W-1:0]];
    end
  end

  // Stage two: doubled differences and grown doubled radius.
  assign ex = (COORD_W+1)'(qx) - (COORD_W+1)'(rd_q.cx);
  assign ey = (COORD_W+1)'(qy) - (COORD_W+1)'(rd_q.cy);
  assign ez = (COORD_W+1)'(qz) - (COORD_W+1)'(rd_q.cz);

  // Stage three: squares and the height test.
  assign adz = s2_dz[DIFF_W-1] ? DIFF_W'(-s2_dz) : DIFF_W'(s2_dz);
  assign px2 = s2_dx * s2_dx;
  assign py2 = s2_dy * s2_dy;
  assign pz2 = s2_dz * s2_dz;
  assign rr  = s2_r * s2_r;

  // Stage four: sums and comparison against the squared radius.
  assign sxy     = CMP_W'(s3_sqx) + CMP_W'(s3_sqy);
  assign sxyz    = sxy + CMP_W'(s3_sqz);
  assign hit_now = s3_cyl ? ((sxy < CMP_W'(s3_rr)) && s3_zin) : (sxyz < CMP_W'(s3_rr));

  always_ff @(posedge clk) begin
    s2_dx  <= {ex, 1'b0};
    s2_dy  <= {ey, 1'b0};
    s2_dz  <= {ez, 1'b0};
    s2_r   <= RAD_W'(rd_q.diam) + RAD_W'({cfg.clearance, 1'b0});
    s2_cyl <= rd_q.is_cyl;
    s2_hgt <= rd_q.hgt;

    s3_sqx <= px2[SQ_W-1:0];
    s3_sqy <= py2[SQ_W-1:0];
    s3_sqz <= pz2[SQ_W-1:0];
    s3_rr  <= rr;
    s3_cyl <= s2_cyl;
    s3_zin <= (adz <= DIFF_W'(s2_hgt));

    if (start_query) begin
      qx     <= cmd.pos_x;
      qy     <= cmd.pos_y;
      qz     <= cmd.pos_z;
      scan_n <= cmd.idx;
      in_box <= box_ok;
      hit    <= 1'b0;
    end else if (v3 && hit_now) begin
      hit <= 1'b1;
    end

    if (load) begin
      res_free   <= load_free;
      res_status <= load_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      scan_idx  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      v1    <= issue;
      v2    <= v1;
      v3    <= v2;
      if (start_query) begin
        scan_idx <= '0;
      end else if (issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  `POC_ASSERT_IMP(a_store_in_table, mem_we, cmd.idx < CNT_W'(MAX_OBSTACLES), "store beyond table")
  `POC_ASSERT_IMP(a_pop_when_idle, cmd_pop, state == BK_IDLE, "command taken outside idle")
  `POC_ASSERT_IMP(a_load_when_free, load, !res_valid || res.ready, "result overwritten")
  `POC_ASSERT(a_pipe_empty, (state == BK_IDLE || state == BK_REPLY) ? drained : 1'b1, "scan pipeline busy")

endmodule

/* hw/rtl/point_obstacle_collision_check.sv */
// A clear or add passes through the command queue and then the result register; a query
// also waits for the scan of the N stored obstacles and for the distance pipeline to drain.
// Throughput: one clear or add per cycle while results are taken; a query holds the back
// end until its reply is loaded, reading one stored obstacle per cycle from the memory.
// Reset clears the obstacle count, command queue and result valid flag and loads the
// register defaults; the obstacle memory keeps its contents.
module point_obstacle_collision_check import poc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  poc_cmd_if.sink               cmd,
  poc_res_if.source             res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  poc_cfg_t cfg;
  logic     push;
  cmd_t     push_data;
  logic     queue_ready;
  cmd_t     head;
  logic     head_valid;
  logic     head_pop;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CLEARANCE:   cfg.clearance     <= pwdata[SIZE_W-1:0];
        REG_BOUND_MIN_X: cfg.bound_min_x   <= pwdata[COORD_W-1:0];
        REG_BOUND_MAX_X: cfg.bound_max_x   <= pwdata[COORD_W-1:0];
        REG_BOUND_MIN_Y: cfg.bound_min_y   <= pwdata[COORD_W-1:0];
        REG_BOUND_MAX_Y: cfg.bound_max_y   <= pwdata[COORD_W-1:0];
        REG_BOUND_MIN_Z: cfg.bound_min_z   <= pwdata[COORD_W-1:0];
        REG_BOUND_MAX_Z: cfg.bound_max_z   <= pwdata[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CLEARANCE:   prdata = CFG_DATA_W'(cfg.clearance);
      REG_BOUND_MIN_X: prdata = CFG_DATA_W'(cfg.bound_min_x);
      REG_BOUND_MAX_X: prdata = CFG_DATA_W'(cfg.bound_max_x);
      REG_BOUND_MIN_Y: prdata = CFG_DATA_W'(cfg.bound_min_y);
      REG_BOUND_MAX_Y: prdata = CFG_DATA_W'(cfg.bound_max_y);
      REG_BOUND_MIN_Z: prdata = CFG_DATA_W'(cfg.bound_min_z);
      REG_BOUND_MAX_Z: prdata = CFG_DATA_W'(cfg.bound_max_z);
      default:         prdata = '0;
    endcase
  end

  poc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .push        (push),
    .push_data   (push_data),
    .queue_ready (queue_ready)
  );

  poc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .push_ready (queue_ready),
    .pop        (head_pop),
    .pop_data   (head),
    .pop_valid  (head_valid)
  );

  poc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (head),
    .cmd_valid (head_valid),
    .cmd_pop   (head_pop),
    .res       (res)
  );

endmodule

/* tb/sv/tb_point_obstacle_collision_check.sv */
`timescale 1ns / 1ps
// Testbench of point_obstacle_collision_check: drives table, query and register traffic
// and checks every result transfer against a behavioural model of the obstacle table.
// Depends on poc_pkg and on the poc_cmd_if and poc_res_if channel interfaces.
module tb_point_obstacle_collision_check;
  import poc_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = MAX_OBSTACLES + 16;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int Q_MIN         = -32768;
  localparam int Q_MAX         = 32767;
  localparam int SIZE_MAX      = 65535;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  typedef struct {
    logic        [1:0]         mode;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic        [1:0]         kind;
    logic        [SIZE_W-1:0]  diam;
    logic        [SIZE_W-1:0]  hgt;
  } cmd_item_t;

  typedef struct {
    logic    pt_free;
    status_t status;
  } reply_t;

  typedef struct {
    int cx;
    int cy;
    int cz;
    bit is_cyl;
    int diam;
    int hgt;
  } obstacle_rec_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  poc_cmd_if cmd_ch ();
  poc_res_if res_ch ();

  point_obstacle_collision_check dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch.sink),
    .res     (res_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  obstacle_rec_t obstacle_tbl [MAX_OBSTACLES];
  int            obstacle_cnt;
  int            clearance;
  int            bound_lo [3];
  int            bound_hi [3];
  reply_t        expected_replies [$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            items_sent  = 0;
  int            error_count = 0;
  int            cycle_count = 0;

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
      $display("point_obstacle_collision_check verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    res_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : result_check
    reply_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: result with none expected, actual point_free=%0b status=%0d",
                 $time, res_ch.point_free, res_ch.status);
        error_count++;
      end else begin
        want = expected_replies.pop_front();
        if (res_ch.point_free !== want.pt_free) begin
          $display("%0t: point_free mismatch, expected %0b actual %0b",
                   $time, want.pt_free, res_ch.point_free);
          error_count++;
        end
        if (res_ch.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d (%s) actual %0d",
                   $time, want.status, want.status.name(), res_ch.status);
          error_count++;
        end
      end
    end
  end

  function automatic void reset_model();
    obstacle_cnt = 0;
    clearance    = int'(CFG_RESET.clearance);
    bound_lo[0]  = int'(CFG_RESET.bound_min_x);
    bound_hi[0]  = int'(CFG_RESET.bound_max_x);
    bound_lo[1]  = int'(CFG_RESET.bound_min_y);
    bound_hi[1]  = int'(CFG_RESET.bound_max_y);
    bound_lo[2]  = int'(CFG_RESET.bound_min_z);
    bound_hi[2]  = int'(CFG_RESET.bound_max_z);
  endfunction

  function automatic bit point_is_free(int px, int py, int pz);
    longint ddx, ddy, ddz, adz, reach, dist2;
    if (px < bound_lo[0] || px > bound_hi[0]) return 1'b0;
    if (py < bound_lo[1] || py > bound_hi[1]) return 1'b0;
    if (pz < bound_lo[2] || pz > bound_hi[2]) return 1'b0;
    for (int i = 0; i < obstacle_cnt; i++) begin
      ddx   = 2 * (longint'(px) - obstacle_tbl[i].cx);
      ddy   = 2 * (longint'(py) - obstacle_tbl[i].cy);
      ddz   = 2 * (longint'(pz) - obstacle_tbl[i].cz);
      reach = longint'(obstacle_tbl[i].diam) + 2 * longint'(clearance);
      dist2 = ddx * ddx + ddy * ddy;
      if (obstacle_tbl[i].is_cyl) begin
        adz = (ddz < 0) ? -ddz : ddz;
        if (dist2 < reach * reach && adz <= obstacle_tbl[i].hgt) return 1'b0;
      end else if (dist2 + ddz * ddz < reach * reach) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic reply_t predict_reply(cmd_item_t it);
    reply_t r;
    r.pt_free = 1'b0;
    r.status  = ST_IGNORED;
    case (it.mode)
      MODE_CLEAR: begin
        obstacle_cnt = 0;
        r.status     = ST_CLEARED;
      end
      MODE_ADD: begin
        if (it.kind == KIND_SPHERE || it.kind == KIND_CYL) begin
          if (obstacle_cnt >= MAX_OBSTACLES) begin
            r.status = ST_FULL;
          end else begin
            obstacle_tbl[obstacle_cnt].cx     = int'(it.pos_x);
            obstacle_tbl[obstacle_cnt].cy     = int'(it.pos_y);
            obstacle_tbl[obstacle_cnt].cz     = int'(it.pos_z);
            obstacle_tbl[obstacle_cnt].is_cyl = (it.kind == KIND_CYL);
            obstacle_tbl[obstacle_cnt].diam   = int'(it.diam);
            obstacle_tbl[obstacle_cnt].hgt    = int'(it.hgt);
            obstacle_cnt++;
            r.status = ST_STORED;
          end
        end
      end
      MODE_QUERY: begin
        r.pt_free = point_is_free(int'(it.pos_x), int'(it.pos_y), int'(it.pos_z));
        r.status  = ST_QUERY;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_item_t make_item(logic [1:0] mode, int x, int y, int z,
                                          logic [1:0] kind, int diam, int hgt);
    cmd_item_t it;
    it.mode  = mode;
    it.pos_x = COORD_W'(x);
    it.pos_y = COORD_W'(y);
    it.pos_z = COORD_W'(z);
    it.kind  = kind;
    it.diam  = SIZE_W'(diam);
    it.hgt   = SIZE_W'(hgt);
    return it;
  endfunction

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic cmd_item_t noise_item();
    return make_item(2'($urandom_range(3)), int'($urandom), int'($urandom), int'($urandom),
                     2'($urandom_range(3)), int'($urandom), int'($urandom));
  endfunction

  task automatic send_item(cmd_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.mode       <= it.mode;
    cmd_ch.pos_x      <= it.pos_x;
    cmd_ch.pos_y      <= it.pos_y;
    cmd_ch.pos_z      <= it.pos_z;
    cmd_ch.shape_kind <= it.kind;
    cmd_ch.diameter   <= it.diam;
    cmd_ch.height     <= it.hgt;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    expected_replies.insert(expected_replies.size(), predict_reply(it));
    items_sent++;
  endtask

  task automatic wait_for_replies();
    cmd_ch.valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, int value);
    logic [15:0] v16;
    v16 = 16'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, v16};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_CLEARANCE:   clearance   = int'(v16);
      REG_BOUND_MIN_X: bound_lo[0] = int'($signed(v16));
      REG_BOUND_MAX_X: bound_hi[0] = int'($signed(v16));
      REG_BOUND_MIN_Y: bound_lo[1] = int'($signed(v16));
      REG_BOUND_MAX_Y: bound_hi[1] = int'($signed(v16));
      REG_BOUND_MIN_Z: bound_lo[2] = int'($signed(v16));
      REG_BOUND_MAX_Z: bound_hi[2] = int'($signed(v16));
      default: ;
    endcase
  endtask

  task automatic apply_config(int safe, int lo_x, int hi_x, int lo_y, int hi_y,
                              int lo_z, int hi_z);
    write_reg(REG_CLEARANCE, safe);
    write_reg(REG_BOUND_MIN_X, lo_x);
    write_reg(REG_BOUND_MAX_X, hi_x);
    write_reg(REG_BOUND_MIN_Y, lo_y);
    write_reg(REG_BOUND_MAX_Y, hi_y);
    write_reg(REG_BOUND_MIN_Z, lo_z);
    write_reg(REG_BOUND_MAX_Z, hi_z);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic test_reset_box();
    send_item(make_item(MODE_QUERY, -5120, -5120, 0, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 5120, 5120, 2560, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 5121, 0, 100, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 0, -5121, 100, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, -1, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, 2561, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, Q_MIN, Q_MAX, Q_MIN, KIND_CYL, SIZE_MAX, SIZE_MAX));
  endtask

  task automatic test_sphere_surface();
    send_item(make_item(MODE_ADD, 0, 0, 1280, KIND_SPHERE, 256, 0));
    send_item(make_item(MODE_QUERY, 256, 0, 1280, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 255, 0, 1280, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 0, -256, 1280, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 0, 0, 1025, KIND_SPHERE, 0, 0));
  endtask

  task automatic test_cylinder_ends();
    send_item(make_item(MODE_CLEAR, 0, 0, 0, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_ADD, 2560, 0, 1280, KIND_CYL, 256, 512));
    send_item(make_item(MODE_QUERY, 2560, 0, 1536, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 2560, 0, 1537, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 2560, 0, 1024, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 2560, 0, 1023, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 2815, 0, 1280, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 2816, 0, 1280, KIND_SPHERE, 0, 0));
  endtask

  task automatic test_ignored_items();
    send_item(make_item(MODE_ADD, Q_MAX, Q_MAX, Q_MAX, KIND_OTHER, SIZE_MAX, SIZE_MAX));
    send_item(make_item(MODE_ADD, Q_MIN, Q_MIN, Q_MIN, KIND_SPARE, 0, 0));
    send_item(make_item(MODE_UNUSED, -1, -1, -1, KIND_SPARE, SIZE_MAX, SIZE_MAX));
    send_item(make_item(MODE_ADD, Q_MIN, Q_MAX, Q_MIN, KIND_SPHERE, SIZE_MAX, SIZE_MAX));
    send_item(make_item(MODE_ADD, Q_MAX, Q_MIN, Q_MAX, KIND_CYL, SIZE_MAX, SIZE_MAX));
    send_item(make_item(MODE_QUERY, -5120, 5120, 0, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 5120, -5120, 2560, KIND_SPHERE, 0, 0));
  endtask

  task automatic test_table_full();
    send_item(make_item(MODE_CLEAR, 0, 0, 0, KIND_SPHERE, 0, 0));
    for (int i = 0; i < MAX_OBSTACLES; i++)
      send_item(make_item(MODE_ADD, -5000 + 150 * i, 4000, 1000,
                          (i % 2 == 0) ? KIND_SPHERE : KIND_CYL, 64, 256));
    send_item(make_item(MODE_ADD, 0, 0, 0, KIND_SPHERE, 64, 0));
    send_item(make_item(MODE_ADD, 0, 0, 0, KIND_CYL, 64, 64));
    send_item(make_item(MODE_ADD, 0, 0, 0, KIND_OTHER, 64, 64));
    send_item(make_item(MODE_QUERY, 0, 0, 1000, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, -5000 + 150 * (MAX_OBSTACLES - 1), 4000, 1000,
                        KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_CLEAR, 0, 0, 0, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, -5000, 4000, 1000, KIND_SPHERE, 0, 0));
  endtask

  task automatic test_register_extremes();
    wait_for_replies();
    apply_config(SIZE_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_item(make_item(MODE_CLEAR, 0, 0, 0, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, Q_MAX, Q_MIN, Q_MAX, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_ADD, 0, 0, 0, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, Q_MAX, Q_MAX, Q_MAX, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, Q_MIN, Q_MIN, Q_MIN, KIND_SPHERE, 0, 0));
    wait_for_replies();
    apply_config(0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_item(make_item(MODE_QUERY, 0, 0, 0, KIND_SPHERE, 0, 0));
    wait_for_replies();
    apply_config(128, 1, 0, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
    send_item(make_item(MODE_QUERY, 0, 0, 0, KIND_SPHERE, 0, 0));
    send_item(make_item(MODE_QUERY, 1, 5, 5, KIND_SPHERE, 0, 0));
  endtask

  task automatic pick_config();
    int sel, half_x, half_y;
    sel = $urandom_range(7);
    half_x = rand_span(3000, 8000);
    half_y = rand_span(3000, 8000);
    wait_for_replies();
    case (sel)
      0: apply_config(0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      1: apply_config(SIZE_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
      2: apply_config(rand_span(0, 256), 100, -100, -half_y, half_y, Q_MIN, Q_MAX);
      3: apply_config(rand_span(0, 256), -half_x, half_x, -half_y, half_y, 2000, 1000);
      default:
        apply_config(rand_span(0, 512), -half_x, half_x, -half_y, half_y,
                     -rand_span(0, 500), rand_span(2000, 4000));
    endcase
  endtask

  task automatic run_scene();
    int n_obst, n_query, pick, reach, z_reach;
    int sx [$], sy [$], sz [$], sr [$], sh [$];
    cmd_item_t it;
    send_item(make_item(MODE_CLEAR, 0, 0, 0, KIND_SPHERE, 0, 0));
    n_obst = ($urandom_range(9) == 0) ? MAX_OBSTACLES + $urandom_range(2) : $urandom_range(8);
    repeat (n_obst) begin
      it = make_item(MODE_ADD, rand_span(-3000, 3000), rand_span(-3000, 3000),
                     rand_span(0, 2560), $urandom_range(1) ? KIND_CYL : KIND_SPHERE,
                     rand_span(32, 1024), rand_span(32, 2048));
      sx.insert(sx.size(), int'(it.pos_x));
      sy.insert(sy.size(), int'(it.pos_y));
      sz.insert(sz.size(), int'(it.pos_z));
      sr.insert(sr.size(), int'(it.diam) / 2 + clearance + 32);
      sh.insert(sh.size(), int'(it.hgt) / 2 + 32);
      send_item(it);
    end
    n_query = rand_span(3, 12);
    repeat (n_query) begin
      if ($urandom_range(9) == 0) begin
        send_item(noise_item());
      end else if (sx.size() == 0) begin
        send_item(make_item(MODE_QUERY, rand_span(-9000, 9000), rand_span(-9000, 9000),
                            rand_span(-600, 4200), KIND_SPHERE, 0, 0));
      end else begin
        pick    = $urandom_range(sx.size() - 1);
        reach   = sr[pick];
        z_reach = (sh[pick] > reach) ? sh[pick] : reach;
        send_item(make_item(MODE_QUERY, sx[pick] + rand_span(-reach, reach),
                            sy[pick] + rand_span(-reach, reach),
                            sz[pick] + rand_span(-z_reach, z_reach), KIND_SPHERE, 0, 0));
      end
    end
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    int stop_at;
    stop_at        = items_sent + n_items;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    while (items_sent < stop_at) begin
      pick_config();
      repeat (4) begin
        if (items_sent < stop_at) run_scene();
      end
    end
  endtask

  initial begin
    rst               <= 1'b1;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    cmd_ch.valid      <= 1'b0;
    cmd_ch.mode       <= MODE_CLEAR;
    cmd_ch.pos_x      <= '0;
    cmd_ch.pos_y      <= '0;
    cmd_ch.pos_z      <= '0;
    cmd_ch.shape_kind <= KIND_SPHERE;
    cmd_ch.diameter   <= '0;
    cmd_ch.height     <= '0;
    reset_model();
    send_idle_pct  = 8;
    recv_stall_pct = 76;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_reset_box();
    test_sphere_surface();
    test_cylinder_ends();
    test_ignored_items();
    test_table_full();
    test_register_extremes();
    test_random_traffic(8, 76, RANDOM_ITEMS / 3);
    test_random_traffic(76, 8, RANDOM_ITEMS / 3);
    test_random_traffic(0, 0, RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("point_obstacle_collision_check verification clean");
    end else begin
      $display("point_obstacle_collision_check verification failed");
    end
    $finish;
  end

endmodule
